// ----- rtl/hrsp_pkg.sv -----
// shared types, character codes and helper functions for the response parser
`default_nettype none

package hrsp_pkg;

  // character codes
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_C  = 8'h63;

  // length of the transfer keyword
  localparam logic [2:0] KW_LEN = 3'd7;

  // status code ceiling
  localparam logic [13:0] STATUS_MAX = 14'd999;

  // top-level phase of the response
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_PASS   = 3'd1,
    PH_SIZE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_SKIP1  = 3'd4,
    PH_SKIP2  = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  // progress through the first line
  typedef enum logic [2:0] {
    SL_LEAD       = 3'd0,
    SL_TOK1       = 3'd1,
    SL_CODE       = 3'd2,
    SL_CODE_OTHER = 3'd3,
    SL_AFTER      = 3'd4,
    SL_CONFIRMED  = 3'd5,
    SL_NOCODE     = 3'd6
  } status_line_e;

  // progress through a chunk size line
  typedef enum logic [1:0] {
    SZ_LEAD    = 2'd0,
    SZ_DIGITS  = 2'd1,
    SZ_STOPPED = 2'd2,
    SZ_CR      = 2'd3
  } size_line_e;

  // input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_response;
  } hrsp_in_t;

  // output request
  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic [9:0] status_code;
    logic       headers_complete;
    logic       chunked_mode;
    logic       truncated_chunk;
    logic       final_result;
  } hrsp_out_t;

  // per-byte flags from the body decoder
  typedef struct packed {
    logic body_valid;
    logic headers_complete;
    logic chunked_mode;
    logic truncated_chunk;
  } dec_res_t;

  // whitespace set used on the first line and size lines
  function automatic logic is_blank(input logic [7:0] b);
    return b inside {CH_SP, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

  // hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // keyword characters by position
  function automatic logic [7:0] keyword_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h63; // c
      3'd1:    c = 8'h68; // h
      3'd2:    c = 8'h75; // u
      3'd3:    c = 8'h6e; // n
      3'd4:    c = 8'h6b; // k
      3'd5:    c = 8'h65; // e
      3'd6:    c = 8'h64; // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hrsp_status_line.sv -----
// first-line tracker that extracts the status code
`default_nettype none

module hrsp_status_line
  import hrsp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       fin_i,
  output logic      [9:0] status_code_o
);

  status_line_e sl_q, sl_d, sl_n;
  logic [9:0]   acc_q, acc_d, acc_n;
  logic [13:0]  acc_sum;
  logic         is_digit;

  // decimal accumulate with saturation
  assign is_digit = byte_i inside {[8'h30:8'h39]};
  assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {10'd0, byte_i[3:0]};

  // first-line progress
  always_comb begin
    sl_n  = sl_q;
    acc_n = acc_q;
    if (sl_q != SL_NOCODE && sl_q != SL_CONFIRMED) begin
      if (byte_i == CH_LF) begin
        sl_n  = SL_NOCODE;
        acc_n = '0;
      end else begin
        case (sl_q)
          SL_LEAD: begin
            if (!is_blank(byte_i)) sl_n = SL_TOK1;
          end
          SL_TOK1: begin
            if (byte_i == CH_SP) begin
              sl_n  = SL_CODE;
              acc_n = '0;
            end
          end
          SL_CODE, SL_CODE_OTHER: begin
            if (byte_i == CH_SP) begin
              sl_n = SL_AFTER;
            end else if (sl_q == SL_CODE && is_digit) begin
              acc_n = (acc_sum > STATUS_MAX) ? STATUS_MAX[9:0] : acc_sum[9:0];
            end else begin
              sl_n = SL_CODE_OTHER;
            end
          end
          SL_AFTER: begin
            if (!is_blank(byte_i)) sl_n = SL_CONFIRMED;
          end
          default: ;
        endcase
      end
    end
  end

  // code reported for this byte, then return to the start on the last byte
  assign status_code_o = (sl_n == SL_CONFIRMED) ? acc_n : '0;
  assign sl_d          = fin_i ? SL_LEAD : sl_n;
  assign acc_d         = fin_i ? '0 : acc_n;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_q  <= SL_LEAD;
      acc_q <= '0;
    end else if (fire_i) begin
      sl_q  <= sl_d;
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hrsp_body_decode.sv -----
// header end detection, keyword search and chunked body decoding
`default_nettype none

module hrsp_body_decode
  import hrsp_pkg::*;
#(
  parameter int CHUNK_SIZE_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       fin_i,
  output dec_res_t        res_o
);

  localparam logic [CHUNK_SIZE_BITS-1:0] CrOne = {{(CHUNK_SIZE_BITS-1){1'b0}}, 1'b1};

  phase_e                     ph_q, ph_d, ph_n;
  logic [2:0]                 wmc_q, wmc_d, wmc_n;
  logic [2:0]                 blm_q, blm_d, blm_n;
  logic                       chk_q, chk_d, chk_n;
  logic [CHUNK_SIZE_BITS-1:0] cr_q, cr_d, cr_n;
  size_line_e                 szf_q, szf_d, szf_n;
  logic [4:0]                 hex;
  logic                       hdr_end;
  logic                       body_valid;

  assign hex = hex_digit(byte_i);

  // per-byte phase logic
  always_comb begin
    ph_n       = ph_q;
    wmc_n      = wmc_q;
    blm_n      = blm_q;
    chk_n      = chk_q;
    cr_n       = cr_q;
    szf_n      = szf_q;
    hdr_end    = 1'b0;
    body_valid = 1'b0;
    case (ph_q)
      PH_HEADER: begin
        // keyword search
        if (wmc_q < KW_LEN && byte_i == keyword_char(wmc_q)) begin
          if (wmc_q + 3'd1 == KW_LEN) begin
            chk_n = 1'b1;
            wmc_n = 3'd0;
          end else begin
            wmc_n = wmc_q + 3'd1;
          end
        end else begin
          wmc_n = (byte_i == CH_C) ? 3'd1 : 3'd0;
        end
        // blank-line search
        if (byte_i == CH_LF) begin
          if (blm_q inside {3'd2, 3'd3, 3'd4}) begin
            hdr_end = 1'b1;
          end else begin
            blm_n = (blm_q == 3'd1) ? 3'd2 : 3'd4;
          end
        end else if (byte_i == CH_CR) begin
          blm_n = (blm_q == 3'd2) ? 3'd3 : 3'd1;
        end else begin
          blm_n = 3'd0;
        end
        if (hdr_end) begin
          ph_n  = chk_n ? PH_SIZE : PH_PASS;
          cr_n  = '0;
          szf_n = SZ_LEAD;
        end
      end
      PH_PASS: begin
        body_valid = 1'b1;
      end
      PH_SIZE: begin
        if (szf_q == SZ_CR && byte_i == CH_LF) begin
          ph_n = (cr_q == '0) ? PH_DONE : PH_DATA;
        end else if (byte_i == CH_CR) begin
          szf_n = SZ_CR;
        end else if (szf_q == SZ_LEAD && is_blank(byte_i)) begin
          szf_n = SZ_LEAD;
        end else if ((szf_q == SZ_LEAD || szf_q == SZ_DIGITS) && hex[4]) begin
          // shift in a nibble, saturating on overflow
          if (|cr_q[CHUNK_SIZE_BITS-1 -: 4]) begin
            cr_n = '1;
          end else begin
            cr_n = {cr_q[CHUNK_SIZE_BITS-5:0], hex[3:0]};
          end
          szf_n = SZ_DIGITS;
        end else begin
          szf_n = SZ_STOPPED;
        end
      end
      PH_DATA: begin
        body_valid = 1'b1;
        cr_n       = cr_q - CrOne;
        if (cr_n == '0) ph_n = PH_SKIP1;
      end
      PH_SKIP1: begin
        ph_n = PH_SKIP2;
      end
      PH_SKIP2: begin
        ph_n  = PH_SIZE;
        cr_n  = '0;
        szf_n = SZ_LEAD;
      end
      default: ;
    endcase
  end

  // result flags for this byte
  always_comb begin
    res_o.body_valid       = body_valid;
    res_o.headers_complete = (ph_n != PH_HEADER);
    res_o.chunked_mode     = chk_n;
    res_o.truncated_chunk  = fin_i && (ph_n == PH_DATA) && (cr_n != '0);
  end

  // the last byte of a response returns everything to the start
  always_comb begin
    ph_d  = fin_i ? PH_HEADER : ph_n;
    wmc_d = fin_i ? 3'd0 : wmc_n;
    blm_d = fin_i ? 3'd0 : blm_n;
    chk_d = fin_i ? 1'b0 : chk_n;
    cr_d  = fin_i ? '0 : cr_n;
    szf_d = fin_i ? SZ_LEAD : szf_n;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_HEADER;
      wmc_q <= 3'd0;
      blm_q <= 3'd0;
      chk_q <= 1'b0;
      cr_q  <= '0;
      szf_q <= SZ_LEAD;
    end else if (fire_i) begin
      ph_q  <= ph_d;
      wmc_q <= wmc_d;
      blm_q <= blm_d;
      chk_q <= chk_d;
      cr_q  <= cr_d;
      szf_q <= szf_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/http_response_stream_parser_core.sv -----
// HTTP response parser: status code, header end, chunked body decoding
// A request waits in the input register; its result is then registered in the output register.
// Throughput: one byte per cycle unless the output stalls, set by the per-byte state update.
// Input and output registers decouple the sides, so one new byte is taken while a result waits.
// Reset clears all parsing state to the start of a response; the byte that carries
// end_of_response returns the state to the same point.
`default_nettype none

module http_response_stream_parser_core
  import hrsp_pkg::*;
#(
  parameter int CHUNK_SIZE_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire hrsp_in_t  in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output hrsp_out_t      out_req_o
);

  logic       in_valid_q;
  hrsp_in_t   in_q;
  logic       out_valid_q;
  hrsp_out_t  out_q;
  logic       out_free;
  logic       fire;
  logic [9:0] status_code;
  dec_res_t   dec_res;
  hrsp_out_t  result;

  // pipeline handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // status line tracking
  hrsp_status_line u_status (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .byte_i        (in_q.data_byte),
    .fin_i         (in_q.end_of_response),
    .status_code_o (status_code)
  );

  // header and body decoding
  hrsp_body_decode #(
    .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_q.data_byte),
    .fin_i  (in_q.end_of_response),
    .res_o  (dec_res)
  );

  // result assembly
  always_comb begin
    result.body_byte        = dec_res.body_valid ? in_q.data_byte : 8'd0;
    result.body_valid       = dec_res.body_valid;
    result.status_code      = status_code;
    result.headers_complete = dec_res.headers_complete;
    result.chunked_mode     = dec_res.chunked_mode;
    result.truncated_chunk  = dec_res.truncated_chunk;
    result.final_result     = in_q.end_of_response;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_body_after_headers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.body_valid) |-> out_req_o.headers_complete)
    else $error("body byte before header end");

  a_trunc_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.truncated_chunk) |-> out_req_o.final_result)
    else $error("truncation flagged on a non-final result");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.status_code <= 10'd999))
    else $error("status code out of range");

endmodule

`default_nettype wire

// ----- tb/http_response_checker.sv -----
// checker for the response parser: predicts each result from accepted requests and compares
module http_response_checker
  import hrsp_pkg::*;
#(
  parameter int CHUNK_SIZE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  hrsp_in_t  in_req_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  hrsp_out_t out_req_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  // progress of the blank line search in the headers
  localparam logic [2:0] BL_NONE   = 3'd0;
  localparam logic [2:0] BL_CR     = 3'd1;
  localparam logic [2:0] BL_CRLF   = 3'd2;
  localparam logic [2:0] BL_CRLFCR = 3'd3;
  localparam logic [2:0] BL_LF     = 3'd4;

  localparam logic [55:0] KEYWORD = "chunked";
  localparam logic [CHUNK_SIZE_BITS-1:0] SIZE_ALL_ONES = '1;

  // predicted parser state
  phase_e                     ph;
  status_line_e               line_st;
  size_line_e                 size_st;
  logic [9:0]                 code_acc;
  logic [2:0]                 kw_pos;
  logic [2:0]                 blank_st;
  logic                       chunked_seen;
  logic [CHUNK_SIZE_BITS-1:0] chunk_left;

  hrsp_out_t pending_results[$];
  hrsp_out_t want;
  int        mismatches = 0;
  int        pending = 0;
  int        checked = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;
  assign checked_o    = checked;

  function automatic bit is_ws(input logic [7:0] b);
    return b == CH_SP || b == CH_HT || b == CH_LF || b == CH_VT || b == CH_FF || b == CH_CR;
  endfunction

  function automatic int hex_value(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // back to the start of a response
  function automatic void restart_parse();
    ph           = PH_HEADER;
    line_st      = SL_LEAD;
    size_st      = SZ_LEAD;
    code_acc     = '0;
    kw_pos       = '0;
    blank_st     = BL_NONE;
    chunked_seen = 1'b0;
    chunk_left   = '0;
  endfunction

  // one byte through the predicted parser
  function automatic hrsp_out_t decode_byte(input hrsp_in_t req);
    hrsp_out_t  res;
    logic [7:0] b;
    int         acc;
    int         hx;
    bit         emit;
    bit         blank_done;
    b          = req.data_byte;
    emit       = 1'b0;
    blank_done = 1'b0;

    // status code from the first line
    if (line_st != SL_NOCODE && line_st != SL_CONFIRMED) begin
      if (b == CH_LF) begin
        line_st  = SL_NOCODE;
        code_acc = '0;
      end else begin
        case (line_st)
          SL_LEAD: if (!is_ws(b)) line_st = SL_TOK1;
          SL_TOK1: if (b == CH_SP) begin
            line_st  = SL_CODE;
            code_acc = '0;
          end
          SL_CODE, SL_CODE_OTHER: begin
            if (b == CH_SP) begin
              line_st = SL_AFTER;
            end else if (line_st == SL_CODE && b >= "0" && b <= "9") begin
              acc      = 10 * int'(code_acc) + int'(b[3:0]);
              code_acc = (acc > 999) ? 10'd999 : acc[9:0];
            end else begin
              line_st = SL_CODE_OTHER;
            end
          end
          default: if (!is_ws(b)) line_st = SL_CONFIRMED;
        endcase
      end
    end

    // headers, then body
    case (ph)
      PH_HEADER: begin
        if (b == KEYWORD[55 - 8*kw_pos -: 8]) begin
          if (kw_pos == 3'd6) begin
            chunked_seen = 1'b1;
            kw_pos       = '0;
          end else begin
            kw_pos = kw_pos + 3'd1;
          end
        end else begin
          kw_pos = (b == CH_C) ? 3'd1 : 3'd0;
        end
        if (b == CH_LF) begin
          if (blank_st == BL_CRLF || blank_st == BL_CRLFCR || blank_st == BL_LF) begin
            blank_done = 1'b1;
          end else begin
            blank_st = (blank_st == BL_CR) ? BL_CRLF : BL_LF;
          end
        end else if (b == CH_CR) begin
          blank_st = (blank_st == BL_CRLF) ? BL_CRLFCR : BL_CR;
        end else begin
          blank_st = BL_NONE;
        end
        if (blank_done) begin
          ph         = chunked_seen ? PH_SIZE : PH_PASS;
          chunk_left = '0;
          size_st    = SZ_LEAD;
        end
      end
      PH_PASS: emit = 1'b1;
      PH_SIZE: begin
        hx = hex_value(b);
        if (size_st == SZ_CR && b == CH_LF) begin
          ph = (chunk_left == 0) ? PH_DONE : PH_DATA;
        end else if (b == CH_CR) begin
          size_st = SZ_CR;
        end else if (!(size_st == SZ_LEAD && is_ws(b))) begin
          if ((size_st == SZ_LEAD || size_st == SZ_DIGITS) && hx >= 0) begin
            // size saturates instead of wrapping
            if (chunk_left > (SIZE_ALL_ONES >> 4)) begin
              chunk_left = SIZE_ALL_ONES;
            end else begin
              chunk_left = {chunk_left[CHUNK_SIZE_BITS-5:0], 4'(hx)};
            end
            size_st = SZ_DIGITS;
          end else begin
            size_st = SZ_STOPPED;
          end
        end
      end
      PH_DATA: begin
        emit       = 1'b1;
        chunk_left = chunk_left - 1'b1;
        if (chunk_left == 0) ph = PH_SKIP1;
      end
      PH_SKIP1: ph = PH_SKIP2;
      PH_SKIP2: begin
        ph         = PH_SIZE;
        chunk_left = '0;
        size_st    = SZ_LEAD;
      end
      default: ;
    endcase

    res.body_byte        = emit ? b : 8'h00;
    res.body_valid       = emit;
    res.status_code      = (line_st == SL_CONFIRMED) ? code_acc : 10'd0;
    res.headers_complete = (ph != PH_HEADER);
    res.chunked_mode     = chunked_seen;
    res.truncated_chunk  = req.end_of_response && ph == PH_DATA && chunk_left != 0;
    res.final_result     = req.end_of_response;
    if (req.end_of_response) restart_parse();
    return res;
  endfunction

  function automatic int field_diff(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // compare accepted results, then predict for the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parse();
      pending_results.delete();
      pending <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (pending_results.size() == 0) begin
          $error("result %h with no request outstanding", out_req_i);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          mismatches += field_diff("body_byte", want.body_byte, out_req_i.body_byte);
          mismatches += field_diff("body_valid", want.body_valid, out_req_i.body_valid);
          mismatches += field_diff("status_code", want.status_code, out_req_i.status_code);
          mismatches += field_diff("headers_complete", want.headers_complete,
                                   out_req_i.headers_complete);
          mismatches += field_diff("chunked_mode", want.chunked_mode, out_req_i.chunked_mode);
          mismatches += field_diff("truncated_chunk", want.truncated_chunk,
                                   out_req_i.truncated_chunk);
          mismatches += field_diff("final_result", want.final_result, out_req_i.final_result);
        end
      end
      if (in_valid_i && !in_stall_i) pending_results.push_back(decode_byte(in_req_i));
      pending <= pending_results.size();
    end
  end

endmodule

// ----- tb/http_response_stream_parser_core_tb.sv -----
// testbench top for the response parser: response stimulus, flow control and verdict
module http_response_stream_parser_core_tb;
  import hrsp_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_BYTES  = 260;
  localparam int DRAIN_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  hrsp_in_t  in_req = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  hrsp_out_t out_req;

  int fail_count;
  int pending;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_served = 0;
  int bytes_sent = 0;
  int responses = 0;
  int quiet_cycles = 0;

  logic [7:0] resp_q[$];

  http_response_stream_parser_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  http_response_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_req_i    (out_req),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold whenever one is requested
  always begin
    @(posedge clk);
    if (hold_served != hold_req) begin
      hold_served++;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // response building
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) resp_q.push_back(s[i]);
  endtask

  task automatic put_eol(input bit bare_lf);
    if (!bare_lf) resp_q.push_back(CH_CR);
    resp_q.push_back(CH_LF);
  endtask

  task automatic put_random(input int n, input bit printable);
    for (int i = 0; i < n; i++) begin
      resp_q.push_back(printable ? 8'($urandom_range(33, 126)) : 8'($urandom_range(255)));
    end
  endtask

  // blank characters; a size line treats LF as blank but CR as its end
  task automatic put_blanks(input int n, input bit size_line);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0:       c = CH_SP;
        1:       c = CH_HT;
        2:       c = CH_VT;
        3:       c = CH_FF;
        default: c = size_line ? CH_LF : CH_CR;
      endcase
      resp_q.push_back(c);
    end
  endtask

  // one random response, mostly well formed
  task automatic build_response();
    int  kind;
    int  variant;
    int  n;
    int  size;
    bit  bare;
    bit  chunked_hdr;
    string hex;
    kind = $urandom_range(99);
    bare = ($urandom_range(3) == 0);

    // plain noise, with line ends sprinkled in
    if (kind < 6) begin
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(5) == 0) begin
          resp_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
        end else begin
          resp_q.push_back(8'($urandom_range(255)));
        end
      end
      return;
    end

    // status line
    variant = $urandom_range(9);
    if (variant == 0) put_blanks($urandom_range(1, 3), 1'b0);
    put_text("HTTP/1.1 ");
    case (variant)
      1:       put_text($sformatf("%0d", $urandom_range(1000, 99999)));
      2:       put_text("2x4");
      3:       ;
      default: put_text($sformatf("%0d", $urandom_range(100, 599)));
    endcase
    if (variant == 5) begin
      put_text(" ");
      put_blanks($urandom_range(0, 2), 1'b0);
    end else if (variant != 4) begin
      put_text(" ");
      put_random($urandom_range(1, 6), 1'b1);
    end
    put_eol(bare);

    // header lines, with or without the transfer keyword
    chunked_hdr = ($urandom_range(99) < 60);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      put_text("X-");
      put_random($urandom_range(1, 8), 1'b1);
      put_text(": ");
      put_random($urandom_range(0, 10), 1'b1);
      put_eol(bare);
    end
    if (chunked_hdr) begin
      case ($urandom_range(3))
        0:       put_text("Transfer-Encoding: chunked");
        1:       put_text("Transfer-Encoding: gzip, chunked");
        2:       put_text("TE: cchunked");
        default: put_text("X-Enc: chunkchunked");
      endcase
      put_eol(bare);
    end else if ($urandom_range(1)) begin
      put_text($urandom_range(1) ? "Transfer-Encoding: Chunked" : "TE: chunke d");
      put_eol(bare);
    end
    put_eol(bare);

    // body
    if (chunked_hdr) begin
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if ($urandom_range(3) == 0) put_blanks($urandom_range(1, 2), 1'b1);
        if ($urandom_range(4) == 0) put_text("00");
        hex = $sformatf("%0h", size);
        put_text($urandom_range(1) ? hex.toupper() : hex);
        if ($urandom_range(4) == 0) put_text(";ext=1");
        put_eol(1'b0);
        put_random(size, 1'b0);
        if ($urandom_range(7) == 0) put_random(2, 1'b0);
        else put_eol(1'b0);
      end
      case ($urandom_range(9))
        0: begin
          // oversized size line, ends inside its data
          put_text("FFFFFFFF");
          put_text($sformatf("%0h", $urandom_range(255)));
          put_eol(1'b0);
          put_random($urandom_range(1, 5), 1'b0);
        end
        1: begin
          case ($urandom_range(3))
            0:       put_text("-5");
            1:       put_text("g");
            2:       put_text("+1");
            default: ;
          endcase
          put_eol(1'b0);
          put_random($urandom_range(0, 6), 1'b0);
        end
        2: ;
        default: begin
          put_text("0");
          put_eol(1'b0);
          put_eol(1'b0);
          if ($urandom_range(3) == 0) put_random($urandom_range(1, 6), 1'b0);
        end
      endcase
    end else begin
      put_random($urandom_range(0, 30), 1'b0);
    end

    // cut short at a random point
    if (kind < 16 && resp_q.size() > 1) begin
      n = $urandom_range(1, resp_q.size() - 1);
      while (resp_q.size() > n) resp_q.delete(resp_q.size() - 1);
    end
  endtask

  // drive one request and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    hrsp_in_t req;
    req.data_byte       = b;
    req.end_of_response = fin;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_response();
    for (int i = 0; i < resp_q.size(); i++) send_byte(resp_q[i], i == resp_q.size() - 1);
    if (resp_q.size() != 0) responses++;
    resp_q.delete();
  endtask

  // sender stops and waits for every result to come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // status saturation, pass-through of extreme bytes
    put_text("H 1000 k\n\n");
    resp_q.push_back(8'hff);
    resp_q.push_back(8'h00);
    send_response();
    // blank before the first token, code with a letter, size line with blank and extension
    resp_q.push_back(CH_HT);
    put_text("H 2x0 y");
    put_eol(1'b0);
    put_text("chunked");
    put_eol(1'b0);
    put_eol(1'b0);
    put_text(" 2;e");
    put_eol(1'b0);
    resp_q.push_back(8'h80);
    resp_q.push_back(8'h7f);
    put_eol(1'b0);
    put_text("0");
    put_eol(1'b0);
    put_text("Zz");
    send_response();
    // no second space, then only blanks after it
    put_text("H 200\n\nZ");
    send_response();
    put_text("H 204 \t\n\n");
    send_response();
    // ends before the headers
    put_text("HT");
    send_response();
    // size overflow, ended inside the chunk
    put_text("H 301 m\nchunked\n\n1FFFFFFFF0");
    put_eol(1'b0);
    put_text("xy");
    send_response();
    // non-numeric size stops decoding
    put_text("H 302 m\nchunked\n\n-1");
    put_eol(1'b0);
    put_text("zz");
    send_response();
    drain();

    // random responses under each flow control mix
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req++;
        end
        1: begin
          idle_pct  = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct  = 17;
          stall_pct = 17;
        end
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_response();
        send_response();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes in %0d responses, %0d results checked", bytes_sent, responses,
             checked);
    $display("flow control ran free, mostly idle, mostly stalled, mixed, and one long hold");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
